// ===== rtl/cyp_pkg.sv =====
`default_nettype none
package cyp_pkg;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 68;

   typedef logic signed [33:0] q30_type;
   typedef logic signed [15:0] q14_type;
   typedef logic signed [31:0] pos_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam logic [2:0] ACT_POINTER  = 3'd0;
   localparam logic [2:0] ACT_STRAFE_R = 3'd1;
   localparam logic [2:0] ACT_STRAFE_L = 3'd2;
   localparam logic [2:0] ACT_FORWARD  = 3'd3;
   localparam logic [2:0] ACT_BACK     = 3'd4;
   localparam logic [2:0] ACT_UP       = 3'd5;
   localparam logic [2:0] ACT_DOWN     = 3'd6;

   localparam logic CSR_SENS  = 1'b0;
   localparam logic CSR_SPEED = 1'b1;

   localparam q30_type CORDIC_GAIN = 34'sd652032874;
   localparam q14_type Q14_ONE     = 16'sd16384;
   localparam pos_type Q16_ONE     = 32'sd65536;

   // arctangent of 2^-i in degrees, 24 fractional bits
   localparam q30_type ATAN_TABLE [24] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
      34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
      34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
      34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
      34'sd917,       34'sd458,       34'sd229,       34'sd115
   };

   function automatic q14_type q14_from_q30(input q30_type v);
      q30_type t;
      q14_type r;
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) begin
         r = Q14_ONE;
      end else if (t < -34'sd16384) begin
         r = -Q14_ONE;
      end else begin
         r = t[15:0];
      end
      return r;
   endfunction

   function automatic q14_type q14_from_q60(input prod_type v);
      prod_type t;
      q14_type r;
      t = (v + (68'sd1 <<< 45)) >>> 46;
      if (t > 68'sd16384) begin
         r = Q14_ONE;
      end else if (t < -68'sd16384) begin
         r = -Q14_ONE;
      end else begin
         r = t[15:0];
      end
      return r;
   endfunction

   function automatic pos_type sat32(input logic signed [35:0] v);
      pos_type r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cyp_mul.sv =====
`default_nettype none
module cyp_mul (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [cyp_pkg::MUL_W-1:0]   a,
   input  wire logic signed [cyp_pkg::MUL_W-1:0]   b,
   output logic                                    done,
   output cyp_pkg::prod_type                       prod
);
   localparam int W  = cyp_pkg::MUL_W;
   localparam int CW = $clog2(W);

   logic signed [W+1:0] hi_ff, hi_in, sum, a_ext;
   logic [W-1:0]        lo_ff, lo_in;
   logic signed [W-1:0] a_ff, a_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   // one multiplier bit per cycle, sign bit weighs negative
   always_comb begin
      a_ext   = (W+2)'(a_ff);
      sum     = hi_ff;
      if (lo_ff[0]) begin
         sum = (cnt_ff == CW'(W-1)) ? hi_ff - a_ext : hi_ff + a_ext;
      end
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = b;
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff[W-1:0], lo_ff};
endmodule
`default_nettype wire

// ===== rtl/cyp_cordic.sv =====
`default_nettype none
module cyp_cordic #(
   parameter int STEPS = 16,
   parameter int AFB   = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [AFB+9:0] angle,
   output logic                       done,
   output cyp_pkg::q30_type           cos_out,
   output cyp_pkg::q30_type           sin_out
);
   localparam int ZSH = 24 - AFB;
   localparam int IW  = $clog2(STEPS);
   localparam logic signed [33:0] QUARTER = 34'sd90 <<< 24;
   localparam logic signed [33:0] HALF    = 34'sd180 <<< 24;

   logic signed [33:0] z0, z_ff, z_in;
   cyp_pkg::q30_type   x_ff, x_in, y_ff, y_in;
   logic               flip_ff, flip_in;
   logic [IW-1:0]      i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      z0      = 34'(angle) <<< ZSH;
      z_in    = z_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      flip_in = flip_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = cyp_pkg::CORDIC_GAIN;
         y_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
         // fold the back half-plane onto the front one
         if (z0 > QUARTER) begin
            z_in    = z0 - HALF;
            flip_in = 1'b1;
         end else if (z0 < -QUARTER) begin
            z_in    = z0 + HALF;
            flip_in = 1'b1;
         end else begin
            z_in    = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - cyp_pkg::ATAN_TABLE[5'(i_ff)];
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + cyp_pkg::ATAN_TABLE[5'(i_ff)];
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      flip_ff <= flip_in;
      i_ff    <= i_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

// ===== rtl/cyp_wrap.sv =====
`default_nettype none
module cyp_wrap #(
   parameter int AFB = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [AFB+18:0] v,
   output logic                        done,
   output logic [AFB+8:0]              yaw
);
   localparam int SW = AFB + 19;
   localparam int YW = AFB + 9;
   localparam int QB = 9;
   localparam logic [SW-1:0] FULL = SW'(360) << AFB;

   logic [SW-1:0] rem_ff, rem_in, div_ff, div_in;
   logic          neg_ff, neg_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [SW-1:0] wrapped;

   // restoring reduction of the magnitude, one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = v[SW-1] ? SW'(-v) : SW'(v);
         div_in  = FULL << (QB - 1);
         neg_in  = v[SW-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= div_ff) begin
            rem_in = rem_ff - div_ff;
         end
         div_in = div_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 4'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign wrapped = (neg_ff && rem_ff != '0) ? FULL - rem_ff : rem_ff;
   assign yaw     = wrapped[YW-1:0];
   assign done    = done_ff;
endmodule
`default_nettype wire

// ===== rtl/camera_yaw_pitch_navigator_core.sv =====
`default_nettype none
// First-person camera: each request is a pointer position (action 0) or a move command
// (1/2 strafe right/left, 3/4 forward/back, 5/6 up/down by exactly 1.0) and each one
// returns the view direction (Q1.14) and saturating position (Q16.16) after it. Requests
// are handled one at a time; a finished response waits in an output register, so the
// next request can be taken while it is pending. The work runs on the bit-serial
// multiplier and the one-iteration-per-cycle CORDIC loop: a pointer move takes four
// multiplies, the yaw wrap and two rotations, a strafe after the first pointer move
// one rotation and three multiplies, forward or back three; up, down and unknown
// actions neither. Configuration writes take effect at once and must come while idle.
module camera_yaw_pitch_navigator_core #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // pointer_x, pointer_y
   input  wire logic [2:0]   req_tuser,   // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,   // dir_x, dir_y, dir_z, pos_x, pos_y, pos_z
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [23:0]  csr_wdata
);
   localparam int AFB = ANGLE_FRAC_BITS;
   localparam int SW  = AFB + 19;
   localparam int YW  = AFB + 9;
   localparam int PW  = AFB + 8;
   localparam int AW  = AFB + 10;
   localparam int SH  = 16 - AFB;
   localparam logic signed [35:0] RND    = (36'sd1 <<< SH) >>> 1;
   localparam logic signed [SW-1:0] LIM  = SW'(89) <<< AFB;
   localparam logic signed [AW-1:0] HALF = AW'(180) <<< AFB;
   localparam logic signed [AW-1:0] FULL = AW'(360) <<< AFB;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL_X     = 4'd1;
   localparam logic [3:0] S_MUL_Y     = 4'd2;
   localparam logic [3:0] S_WRAP      = 4'd3;
   localparam logic [3:0] S_ROT_YAW   = 4'd4;
   localparam logic [3:0] S_ROT_PITCH = 4'd5;
   localparam logic [3:0] S_MUL_DIR   = 4'd6;
   localparam logic [3:0] S_MUL_MOVE  = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic                    go_ff, go_in;
   logic [2:0]              act_ff, act_in;
   logic signed [15:0]      px_ff, px_in, py_ff, py_in;
   logic signed [15:0]      lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic [YW-1:0]           yaw_ff, yaw_in;
   logic signed [PW-1:0]    pitch_ff, pitch_in;
   logic signed [SW-1:0]    v_ff, v_in;
   cyp_pkg::q30_type        cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in;
   cyp_pkg::q14_type        dir_ff [3];
   cyp_pkg::q14_type        dir_in [3];
   cyp_pkg::pos_type        pos_ff [3];
   cyp_pkg::pos_type        pos_in [3];
   cyp_pkg::q14_type        u_ff [3];
   cyp_pkg::q14_type        u_in [3];
   logic [1:0]              k_ff, k_in;
   logic                    aimed_ff, aimed_in;
   logic [15:0]             sens_ff, sens_in;
   logic [23:0]             speed_ff, speed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [143:0]            rsp_data_ff, rsp_data_in;

   logic signed [cyp_pkg::MUL_W-1:0] mul_a, mul_b;
   logic                    mul_start, mul_done;
   cyp_pkg::prod_type       mul_prod;
   logic                    rot_start, rot_done;
   logic signed [AW-1:0]    rot_angle, yaw_ext, yaw_adj;
   cyp_pkg::q30_type        rot_cos, rot_sin;
   logic                    wrap_start, wrap_done;
   logic [YW-1:0]           wrap_yaw;

   logic signed [35:0]      p36, sc;
   logic signed [SW-1:0]    sc_t, pitch_sum;
   cyp_pkg::prod_type       step_full;
   logic signed [35:0]      step, pos_sum, y_sum;
   logic                    move_neg, req_xfer;

   cyp_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   cyp_cordic #(.STEPS (CORDIC_STEPS), .AFB (AFB)) u_cordic (
      .clock (clock), .reset (reset), .start (rot_start), .angle (rot_angle),
      .done (rot_done), .cos_out (rot_cos), .sin_out (rot_sin)
   );

   cyp_wrap #(.AFB (AFB)) u_wrap (
      .clock (clock), .reset (reset), .start (wrap_start), .v (v_ff),
      .done (wrap_done), .yaw (wrap_yaw)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_start  = go_ff && (state_ff == S_MUL_X || state_ff == S_MUL_Y ||
                                 state_ff == S_MUL_DIR || state_ff == S_MUL_MOVE);
   assign rot_start  = go_ff && (state_ff == S_ROT_YAW || state_ff == S_ROT_PITCH);
   assign wrap_start = go_ff && (state_ff == S_WRAP);

   // yaw in (-180, 180] for the rotator
   assign yaw_ext   = $signed({1'b0, yaw_ff});
   assign yaw_adj   = (yaw_ext > HALF) ? yaw_ext - FULL : yaw_ext;
   assign rot_angle = (state_ff == S_ROT_PITCH) ? AW'(pitch_ff) : yaw_adj;

   always_comb begin
      case (state_ff)
         S_MUL_X: begin
            mul_a = cyp_pkg::MUL_W'(17'(px_ff) - 17'(lastx_ff));
            mul_b = cyp_pkg::MUL_W'({1'b0, sens_ff});
         end
         S_MUL_Y: begin
            mul_a = cyp_pkg::MUL_W'(17'(lasty_ff) - 17'(py_ff));
            mul_b = cyp_pkg::MUL_W'({1'b0, sens_ff});
         end
         S_MUL_DIR: begin
            mul_a = (k_ff == 2'd0) ? cy_ff : sy_ff;
            mul_b = cp_ff;
         end
         default: begin
            mul_a = cyp_pkg::MUL_W'(u_ff[k_ff]);
            mul_b = cyp_pkg::MUL_W'({1'b0, speed_ff});
         end
      endcase
   end

   // angle delta rounded to the angle grid, and position step rounded to Q16.16
   always_comb begin
      p36       = mul_prod[35:0];
      sc        = (p36 + RND) >>> SH;
      sc_t      = sc[SW-1:0];
      pitch_sum = SW'(pitch_ff) + sc_t;
      step_full = (mul_prod + 68'sd8192) >>> 14;
      step      = step_full[35:0];
      move_neg  = (act_ff == cyp_pkg::ACT_STRAFE_L) || (act_ff == cyp_pkg::ACT_BACK);
      pos_sum   = move_neg ? 36'(pos_ff[k_ff]) - step : 36'(pos_ff[k_ff]) + step;
      y_sum     = (req_tuser == cyp_pkg::ACT_DOWN) ? 36'(pos_ff[1]) - 36'(cyp_pkg::Q16_ONE)
                                                   : 36'(pos_ff[1]) + 36'(cyp_pkg::Q16_ONE);
   end

   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      act_in       = act_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      lastx_in     = lastx_ff;
      lasty_in     = lasty_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      v_in         = v_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      dir_in       = dir_ff;
      pos_in       = pos_ff;
      u_in         = u_ff;
      k_in         = k_ff;
      aimed_in     = aimed_ff;
      sens_in      = sens_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            cyp_pkg::CSR_SENS:  sens_in  = csr_wdata[15:0];
            cyp_pkg::CSR_SPEED: speed_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in = req_tuser;
               px_in  = req_tdata[15:0];
               py_in  = req_tdata[31:16];
               k_in   = 2'd0;
               case (req_tuser)
                  cyp_pkg::ACT_POINTER: begin
                     state_in = S_MUL_X;
                     go_in    = 1'b1;
                  end
                  cyp_pkg::ACT_STRAFE_R, cyp_pkg::ACT_STRAFE_L: begin
                     if (aimed_ff) begin
                        state_in = S_ROT_YAW;
                     end else begin
                        u_in[0]  = cyp_pkg::Q14_ONE;
                        u_in[1]  = '0;
                        u_in[2]  = '0;
                        state_in = S_MUL_MOVE;
                     end
                     go_in = 1'b1;
                  end
                  cyp_pkg::ACT_FORWARD, cyp_pkg::ACT_BACK: begin
                     u_in     = dir_ff;
                     state_in = S_MUL_MOVE;
                     go_in    = 1'b1;
                  end
                  cyp_pkg::ACT_UP, cyp_pkg::ACT_DOWN: begin
                     pos_in[1] = cyp_pkg::sat32(y_sum);
                     state_in  = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL_X: begin
            if (mul_done) begin
               v_in     = SW'(yaw_ff) + sc_t;
               state_in = S_MUL_Y;
               go_in    = 1'b1;
            end
         end
         S_MUL_Y: begin
            if (mul_done) begin
               if (pitch_sum > LIM) begin
                  pitch_in = PW'(LIM);
               end else if (pitch_sum < -LIM) begin
                  pitch_in = PW'(-LIM);
               end else begin
                  pitch_in = pitch_sum[PW-1:0];
               end
               state_in = S_WRAP;
               go_in    = 1'b1;
            end
         end
         S_WRAP: begin
            if (wrap_done) begin
               yaw_in   = wrap_yaw;
               state_in = S_ROT_YAW;
               go_in    = 1'b1;
            end
         end
         S_ROT_YAW: begin
            if (rot_done) begin
               cy_in = rot_cos;
               sy_in = rot_sin;
               go_in = 1'b1;
               if (act_ff == cyp_pkg::ACT_POINTER) begin
                  state_in = S_ROT_PITCH;
               end else begin
                  // strafe axis (-sin yaw, 0, cos yaw)
                  u_in[0]  = -cyp_pkg::q14_from_q30(rot_sin);
                  u_in[1]  = '0;
                  u_in[2]  = cyp_pkg::q14_from_q30(rot_cos);
                  state_in = S_MUL_MOVE;
               end
            end
         end
         S_ROT_PITCH: begin
            if (rot_done) begin
               cp_in     = rot_cos;
               dir_in[1] = cyp_pkg::q14_from_q30(rot_sin);
               k_in      = 2'd0;
               state_in  = S_MUL_DIR;
               go_in     = 1'b1;
            end
         end
         S_MUL_DIR: begin
            if (mul_done) begin
               if (k_ff == 2'd0) begin
                  dir_in[0] = cyp_pkg::q14_from_q60(mul_prod);
                  k_in      = 2'd1;
                  go_in     = 1'b1;
               end else begin
                  dir_in[2] = cyp_pkg::q14_from_q60(mul_prod);
                  lastx_in  = px_ff;
                  lasty_in  = py_ff;
                  aimed_in  = 1'b1;
                  state_in  = S_DONE;
               end
            end
         end
         S_MUL_MOVE: begin
            if (mul_done) begin
               pos_in[k_ff] = cyp_pkg::sat32(pos_sum);
               if (k_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  k_in  = k_ff + 2'd1;
                  go_in = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pos_ff[2], pos_ff[1], pos_ff[0],
                               dir_ff[2], dir_ff[1], dir_ff[0]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         aimed_ff     <= 1'b0;
         sens_ff      <= 16'd6554;
         speed_ff     <= 24'd6554;
         lastx_ff     <= '0;
         lasty_ff     <= '0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= -cyp_pkg::Q14_ONE;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= cyp_pkg::Q16_ONE;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         aimed_ff     <= aimed_in;
         sens_ff      <= sens_in;
         speed_ff     <= speed_in;
         lastx_ff     <= lastx_in;
         lasty_ff     <= lasty_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         dir_ff       <= dir_in;
         pos_ff       <= pos_in;
      end
      act_ff      <= act_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      v_ff        <= v_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
      u_ff        <= u_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

// ===== tb/camera_yaw_pitch_navigator_core_test.sv =====
`timescale 1ns / 1ps
module camera_yaw_pitch_navigator_core_test;

   localparam logic [2:0] ACT_NONE = 3'd7;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] px;
      logic [15:0] py;
   } nav_cmd_type;

   typedef struct packed {
      logic [15:0] dx, dy, dz;
      logic [31:0] px, py, pz;
   } pose_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;   // pointer_x, pointer_y
   logic [2:0]    req_tuser = '0;   // action
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [143:0]  rsp_tdata;        // dir_x, dir_y, dir_z, pos_x, pos_y, pos_z
   logic          csr_we = 0;
   logic          csr_addr = 0;
   logic [23:0]   csr_wdata = '0;

   camera_yaw_pitch_navigator_core DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   nav_cmd_type cmd_queue[$];
   pose_type    pose_queue[$];
   int       send_idle = 0, recv_stall = 0;
   logic     req_taken = 0;
   int       errors = 0, quiet_cycles = 0, cmds_sent = 0, poses_checked = 0;

   // camera state mirror
   longint sens = 6554, speed = 6554;
   longint last_x, last_y, yaw, pitch;
   longint dir[3], pos[3];
   bit     aimed;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_q14(longint v, int frac);
      return clamp((v + (longint'(1) <<< (frac - 15))) >>> (frac - 14), -16384, 16384);
   endfunction

   // rotation-mode cordic, angle in degrees with 12 fractional bits, results q30
   task automatic cordic_sin_cos(input longint ang, output longint c, output longint s);
      longint z, x, y, xn, quarter;
      bit     flip;
      z = ang <<< 12;
      quarter = longint'(90) <<< 24;
      x = cyp_pkg::CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z > quarter) begin
         z -= 2 * quarter;
         flip = 1;
      end else if (z < -quarter) begin
         z += 2 * quarter;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            xn = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(cyp_pkg::ATAN_TABLE[i]);
         end else begin
            xn = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(cyp_pkg::ATAN_TABLE[i]);
         end
         x = xn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic yaw_sin_cos(output longint c, output longint s);
      longint a;
      a = yaw;
      if (a > (longint'(180) <<< 12)) a -= longint'(360) <<< 12;
      cordic_sin_cos(a, c, s);
   endtask

   task automatic step_along(input longint u0, input longint u1, input longint u2,
                             input longint sgn);
      longint u[3];
      u = '{u0, u1, u2};
      for (int i = 0; i < 3; i++)
         pos[i] = clamp(pos[i] + sgn * ((u[i] * speed + 8192) >>> 14),
                        -64'sd2147483648, 64'sd2147483647);
   endtask

   task automatic predict_pose(input nav_cmd_type cmd);
      longint cy, sy, cp, sp, full, lim, nx, ny;
      pose_type r;
      full = longint'(360) <<< 12;
      lim = longint'(89) <<< 12;
      case (cmd.action)
         cyp_pkg::ACT_POINTER: begin
            nx = longint'($signed(cmd.px));
            ny = longint'($signed(cmd.py));
            yaw = (yaw + ((((nx - last_x) * sens) + 8) >>> 4)) % full;
            if (yaw < 0) yaw += full;
            pitch = clamp(pitch + ((((last_y - ny) * sens) + 8) >>> 4), -lim, lim);
            yaw_sin_cos(cy, sy);
            cordic_sin_cos(pitch, cp, sp);
            dir[0] = round_q14(cy * cp, 60);
            dir[1] = round_q14(sp, 30);
            dir[2] = round_q14(sy * cp, 60);
            last_x = nx;
            last_y = ny;
            aimed = 1;
         end
         cyp_pkg::ACT_STRAFE_R, cyp_pkg::ACT_STRAFE_L: begin
            if (aimed) begin
               yaw_sin_cos(cy, sy);
               step_along(-round_q14(sy, 30), 0, round_q14(cy, 30),
                          cmd.action == cyp_pkg::ACT_STRAFE_R ? 1 : -1);
            end else begin
               step_along(16384, 0, 0, cmd.action == cyp_pkg::ACT_STRAFE_R ? 1 : -1);
            end
         end
         cyp_pkg::ACT_FORWARD, cyp_pkg::ACT_BACK:
            step_along(dir[0], dir[1], dir[2],
                       cmd.action == cyp_pkg::ACT_FORWARD ? 1 : -1);
         cyp_pkg::ACT_UP, cyp_pkg::ACT_DOWN:
            pos[1] = clamp(pos[1] + (cmd.action == cyp_pkg::ACT_UP ? 65536 : -65536),
                           -64'sd2147483648, 64'sd2147483647);
         default: ;
      endcase
      r.dx = dir[0][15:0];
      r.dy = dir[1][15:0];
      r.dz = dir[2][15:0];
      r.px = pos[0][31:0];
      r.py = pos[1][31:0];
      r.pz = pos[2][31:0];
      pose_queue.push_back(r);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               nav_cmd_type c;
               c = cmd_queue.pop_front();
               req_tuser <= c.action;
               req_tdata <= {c.py, c.px};
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_pose('{req_tuser, req_tdata[15:0], req_tdata[31:16]});
            cmds_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            pose_type got, want;
            got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                    rsp_tdata[79:48], rsp_tdata[111:80], rsp_tdata[143:112]};
            if (pose_queue.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, got);
               errors++;
            end else begin
               want = pose_queue.pop_front();
               poses_checked++;
               if (got.dx !== want.dx) begin
                  $display("%0t: dir_x expected %h actual %h", $time, want.dx, got.dx);
                  errors++;
               end
               if (got.dy !== want.dy) begin
                  $display("%0t: dir_y expected %h actual %h", $time, want.dy, got.dy);
                  errors++;
               end
               if (got.dz !== want.dz) begin
                  $display("%0t: dir_z expected %h actual %h", $time, want.dz, got.dz);
                  errors++;
               end
               if (got.px !== want.px) begin
                  $display("%0t: pos_x expected %h actual %h", $time, want.px, got.px);
                  errors++;
               end
               if (got.py !== want.py) begin
                  $display("%0t: pos_y expected %h actual %h", $time, want.py, got.py);
                  errors++;
               end
               if (got.pz !== want.pz) begin
                  $display("%0t: pos_z expected %h actual %h", $time, want.pz, got.pz);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (cmd_queue.size() == 0 && pose_queue.size() == 0 && !req_tvalid))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pose_queue.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic drain();
      while (cmd_queue.size() > 0 || pose_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input longint val);
      drain();
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val[23:0];
      @(negedge clock);
      csr_we <= 0;
      if (idx == cyp_pkg::CSR_SENS) sens = val & 16'hffff;
      else speed = val & 24'hffffff;
   endtask

   task automatic add_cmd(input logic [2:0] a, input logic [15:0] x, input logic [15:0] y);
      cmd_queue.push_back('{a, x, y});
   endtask

   task automatic add_random(input int n);
      logic [15:0] gx, gy;
      int          pick;
      gx = 0;
      gy = 0;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            if ($urandom_range(1)) begin
               gx = 16'($urandom);
               gy = 16'($urandom);
            end else begin
               gx = gx + 16'($urandom_range(200)) - 16'd100;
               gy = gy + 16'($urandom_range(200)) - 16'd100;
            end
            add_cmd(cyp_pkg::ACT_POINTER, gx, gy);
         end else begin
            add_cmd(3'($urandom_range(7)), 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      dir = '{0, 0, -16384};
      pos = '{0, 0, 65536};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // strafe before the first aim, every action, unknown action, pointer extremes
      add_cmd(cyp_pkg::ACT_STRAFE_R, 16'h7fff, 16'h8000);
      add_cmd(cyp_pkg::ACT_STRAFE_L, 16'hffff, 16'h0000);
      add_cmd(cyp_pkg::ACT_FORWARD, 16'h1234, 16'h5678);
      add_cmd(cyp_pkg::ACT_BACK, 16'h0, 16'h0);
      add_cmd(cyp_pkg::ACT_UP, 16'h0, 16'h0);
      add_cmd(cyp_pkg::ACT_DOWN, 16'h0, 16'h0);
      add_cmd(ACT_NONE, 16'hffff, 16'hffff);
      add_cmd(cyp_pkg::ACT_POINTER, 16'h7fff, 16'h8000);
      add_cmd(cyp_pkg::ACT_POINTER, 16'h8000, 16'h7fff);
      add_cmd(cyp_pkg::ACT_POINTER, 16'h0000, 16'h0000);
      add_cmd(cyp_pkg::ACT_POINTER, 16'hffff, 16'hffff);
      add_cmd(cyp_pkg::ACT_POINTER, 16'd40, 16'hfff0);
      add_cmd(cyp_pkg::ACT_STRAFE_R, 16'h0, 16'h0);
      add_cmd(cyp_pkg::ACT_STRAFE_L, 16'h0, 16'h0);
      add_cmd(cyp_pkg::ACT_FORWARD, 16'h0, 16'h0);
      add_cmd(cyp_pkg::ACT_BACK, 16'h0, 16'h0);
      add_cmd(ACT_NONE, 16'h0, 16'h0);
      add_random(100);
      drain();

      csr_write(cyp_pkg::CSR_SENS, 65535);
      csr_write(cyp_pkg::CSR_SPEED, 24'hffffff);
      send_idle = 66;
      // long run in one direction drives the position into saturation
      add_cmd(cyp_pkg::ACT_POINTER, 16'd7, 16'hfffd);
      for (int i = 0; i < 160; i++)
         add_cmd(cyp_pkg::ACT_FORWARD, 16'($urandom), 16'($urandom));
      for (int i = 0; i < 160; i++) add_cmd(cyp_pkg::ACT_STRAFE_L, 16'h0, 16'h0);
      for (int i = 0; i < 10; i++) add_cmd(cyp_pkg::ACT_UP, 16'h0, 16'h0);
      add_random(100);

      csr_write(cyp_pkg::CSR_SENS, 0);
      csr_write(cyp_pkg::CSR_SPEED, 0);
      send_idle = 0;
      recv_stall = 66;
      add_random(150);

      csr_write(cyp_pkg::CSR_SENS, $urandom_range(65535));
      csr_write(cyp_pkg::CSR_SPEED, $urandom_range(24'hffffff));
      send_idle = 37;
      recv_stall = 37;
      add_random(100);
      drain();

      $display("covered %0d commands, %0d poses checked over four idle and register settings",
               cmds_sent, poses_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cyp_pkg.sv
rtl/cyp_mul.sv
rtl/cyp_cordic.sv
rtl/cyp_wrap.sv
rtl/camera_yaw_pitch_navigator_core.sv
tb/camera_yaw_pitch_navigator_core_test.sv
